// ----- sv/bvs_pkg.sv -----
// Shared constants for the barometric vertical speed block.
// Fixed-point constants of the log2 / exp2 datapath and the result status codes.
// No dependencies.
package bvs_pkg;

   localparam int unsigned PRESS_W = 24;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned SPEED_W = 32;
   localparam int unsigned STAT_W  = 2;

   // 0.1903 and ln2, both Q62, truncated
   localparam logic [63:0] EXP_Q62  = 64'd877603849306731918;
   localparam logic [63:0] LN2_Q62  = 64'h2C5C85FDF473DE6A;
   localparam logic [63:0] ONE_Q56  = 64'h0100_0000_0000_0000;
   localparam logic [63:0] ONE_Q62  = 64'h4000_0000_0000_0000;
   // 44330 m expressed in mm, times 1000 for the ms time step; the Q56 scale of the ratio is removed by the final shift
   localparam logic [63:0] SCALE_MM = 64'd44330000000;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_PREV = 2'd1;
   localparam logic [STAT_W-1:0] STAT_ZERO_DT = 2'd2;

   localparam logic [31:0] LIM_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] LIM_NEG = 32'h8000_0000;

   localparam logic [5:0] EXP_TERMS = 6'd40;

endpackage

// ----- sv/barometric_vertical_speed.sv -----
// Barometric variometer: vertical speed in mm/s from two successive pressure samples.
// Input: req_pressure (1/64 Pa) and req_time_ms, valid/ready, one transfer per sample.
// Output: one transfer per sample with rsp_speed_mm_s (signed), rsp_status and
// rsp_saturated. Status 1 when the held previous pressure is zero (none held since
// reset, or a zero sample), 2 when the time step is zero; both give speed 0. Every
// sample becomes the new reference sample.
// A full computation runs on one shared 32x32 multiplier (four passes per 64-bit
// product) and one bit-serial divider: 2 x 56 squarings for the two log2 values,
// up to 40 series terms (each a product and a 64-bit divide), then a scaling
// product and a 128-bit divide by the time step. A zero current pressure skips the
// logs and the series. req_ready is low from the accepted sample until its result
// is moved into the output register.
// The result sits in an output register, so a new sample is taken while it waits;
// a stalled receiver only holds the next result back at its final step.
// Reset (synchronous) clears the held sample, so the first result has status 1.
module barometric_vertical_speed (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bvs_pkg::PRESS_W-1:0]   req_pressure,
   input  logic [bvs_pkg::TIME_W-1:0]    req_time_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [bvs_pkg::SPEED_W-1:0] rsp_speed_mm_s,
   output logic [bvs_pkg::STAT_W-1:0]    rsp_status,
   output logic                          rsp_saturated
);
   import bvs_pkg::*;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CHECK   = 5'd1;
   localparam logic [4:0] S_LOGINIT = 5'd2;
   localparam logic [4:0] S_LOGSQ   = 5'd3;
   localparam logic [4:0] S_LOGW    = 5'd4;
   localparam logic [4:0] S_POW     = 5'd5;
   localparam logic [4:0] S_POWW    = 5'd6;
   localparam logic [4:0] S_EXPX    = 5'd7;
   localparam logic [4:0] S_EXPXW   = 5'd8;
   localparam logic [4:0] S_EXPT    = 5'd9;
   localparam logic [4:0] S_EXPTW   = 5'd10;
   localparam logic [4:0] S_EXPD    = 5'd11;
   localparam logic [4:0] S_SHIFT   = 5'd12;
   localparam logic [4:0] S_SCALE   = 5'd13;
   localparam logic [4:0] S_SCALEW  = 5'd14;
   localparam logic [4:0] S_DIVW    = 5'd15;
   localparam logic [4:0] S_SAT     = 5'd16;
   localparam logic [4:0] S_DONE    = 5'd17;

   logic [4:0]   state_ff;
   logic [23:0]  prev_p_ff, p_ff, pp_ff;
   logic [31:0]  prev_t_ff, dt_ff;
   logic         sel_ff;
   logic [63:0]  m_ff, res_ff, lp_ff;
   logic [5:0]   bit_ff;
   logic         neg_ff, dneg_ff;
   logic [55:0]  fr_ff;
   logic signed [8:0] n_ff;
   logic [63:0]  x_ff, term_ff, sum_ff, r_ff;
   logic [5:0]   k_ff;
   logic [127:0] rnd_ff;
   logic [31:0]  speed_ff;
   logic [STAT_W-1:0] status_ff;
   logic         sat_ff;
   logic         rsp_valid_ff;
   logic [31:0]  out_speed_ff;
   logic [STAT_W-1:0] out_status_ff;
   logic         out_sat_ff;

   logic         mul_start, mul_done;
   logic [63:0]  mul_a, mul_b;
   logic [127:0] mul_prod;
   logic [63:0]  mq62;
   logic         div_start, div_done, div_full;
   logic [127:0] div_dividend, div_quo;
   logic [31:0]  div_divisor;

   logic [23:0]  lx;
   logic [4:0]   lx_msb;
   logic [5:0]   lx_sh;
   logic         lneg;
   logic [63:0]  ldiff;
   logic [8:0]   ip9;
   logic signed [9:0] s_amt;
   logic [63:0]  d_val;
   logic         out_free, accept;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign mq62     = mul_prod[125:62];

   // leading one of the sample being converted
   assign lx = sel_ff ? pp_ff : p_ff;
   always_comb begin
      lx_msb = 5'd0;
      for (int i = 0; i < 24; i++)
         if (lx[i]) lx_msb = 5'(i);
   end
   assign lx_sh = 6'd62 - {1'b0, lx_msb};

   assign lneg  = lp_ff < res_ff;
   assign ldiff = lneg ? res_ff - lp_ff : lp_ff - res_ff;
   assign ip9   = {1'b0, mq62[63:56]};
   assign s_amt = 10'sd6 - 10'(n_ff);
   assign d_val = (r_ff > ONE_Q56) ? r_ff - ONE_Q56 : ONE_Q56 - r_ff;

   always_comb begin
      mul_start = 1'b0;
      mul_a     = m_ff;
      mul_b     = m_ff;
      unique case (state_ff)
         S_LOGSQ: mul_start = 1'b1;
         S_POW: begin
            mul_start = 1'b1;
            mul_a     = ldiff;
            mul_b     = EXP_Q62;
         end
         S_EXPX: begin
            mul_start = 1'b1;
            mul_a     = {2'b00, fr_ff, 6'd0};
            mul_b     = LN2_Q62;
         end
         S_EXPT: begin
            mul_start = 1'b1;
            mul_a     = term_ff;
            mul_b     = x_ff;
         end
         S_SCALE: begin
            mul_start = 1'b1;
            mul_a     = d_val;
            mul_b     = SCALE_MM;
         end
         default: mul_start = 1'b0;
      endcase
   end

   always_comb begin
      div_start    = 1'b0;
      div_full     = 1'b0;
      div_dividend = {mq62, 64'd0};
      div_divisor  = {26'd0, k_ff};
      if (state_ff == S_EXPTW && mul_done) begin
         div_start = 1'b1;
      end else if (state_ff == S_SCALEW && mul_done) begin
         div_start    = 1'b1;
         div_full     = 1'b1;
         div_dividend = mul_prod;
         div_divisor  = dt_ff;
      end
   end

   bvs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   bvs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .full     (div_full),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_p_ff    <= 24'd0;
         prev_t_ff    <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in S_DONE the output register is reloaded below instead
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  p_ff      <= req_pressure;
                  pp_ff     <= prev_p_ff;
                  dt_ff     <= req_time_ms - prev_t_ff;
                  prev_p_ff <= req_pressure;
                  prev_t_ff <= req_time_ms;
                  state_ff  <= S_CHECK;
               end
            end
            S_CHECK: begin
               speed_ff  <= 32'd0;
               sat_ff    <= 1'b0;
               status_ff <= STAT_OK;
               sel_ff    <= 1'b0;
               r_ff      <= 64'd0;
               if (pp_ff == 24'd0) begin
                  status_ff <= STAT_NO_PREV;
                  state_ff  <= S_DONE;
               end else if (dt_ff == 32'd0) begin
                  status_ff <= STAT_ZERO_DT;
                  state_ff  <= S_DONE;
               end else if (p_ff == 24'd0) begin
                  state_ff <= S_SCALE;
               end else begin
                  state_ff <= S_LOGINIT;
               end
            end
            S_LOGINIT: begin
               m_ff     <= {40'd0, lx} << lx_sh;
               res_ff   <= {3'd0, lx_msb, 56'd0};
               bit_ff   <= 6'd55;
               state_ff <= S_LOGSQ;
            end
            S_LOGSQ: state_ff <= S_LOGW;
            S_LOGW: begin
               if (mul_done) begin
                  if (mq62[63]) begin
                     m_ff   <= {1'b0, mq62[63:1]};
                     res_ff <= res_ff | (64'd1 << bit_ff);
                  end else begin
                     m_ff <= mq62;
                  end
                  if (bit_ff != 6'd0) begin
                     bit_ff   <= bit_ff - 6'd1;
                     state_ff <= S_LOGSQ;
                  end else if (!sel_ff) begin
                     lp_ff    <= mq62[63] ? (res_ff | 64'd1) : res_ff;
                     sel_ff   <= 1'b1;
                     state_ff <= S_LOGINIT;
                  end else begin
                     state_ff <= S_POW;
                  end
               end
            end
            S_POW: begin
               neg_ff   <= lneg;
               state_ff <= S_POWW;
            end
            S_POWW: begin
               if (mul_done) begin
                  if (!neg_ff) begin
                     n_ff  <= signed'(ip9);
                     fr_ff <= mq62[55:0];
                  end else if (mq62[55:0] != 56'd0) begin
                     n_ff  <= -signed'(ip9) - 9'sd1;
                     fr_ff <= 56'd0 - mq62[55:0];
                  end else begin
                     n_ff  <= -signed'(ip9);
                     fr_ff <= 56'd0;
                  end
                  state_ff <= S_EXPX;
               end
            end
            S_EXPX: state_ff <= S_EXPXW;
            S_EXPXW: begin
               if (mul_done) begin
                  x_ff     <= mq62;
                  term_ff  <= ONE_Q62;
                  sum_ff   <= ONE_Q62;
                  k_ff     <= 6'd1;
                  state_ff <= S_EXPT;
               end
            end
            S_EXPT: state_ff <= S_EXPTW;
            S_EXPTW: begin
               if (mul_done) state_ff <= S_EXPD;
            end
            S_EXPD: begin
               if (div_done) begin
                  // series stops at the first zero term or after EXP_TERMS terms
                  if (div_quo[63:0] == 64'd0) begin
                     state_ff <= S_SHIFT;
                  end else begin
                     sum_ff  <= sum_ff + div_quo[63:0];
                     term_ff <= div_quo[63:0];
                     k_ff    <= k_ff + 6'd1;
                     state_ff <= (k_ff == EXP_TERMS) ? S_SHIFT : S_EXPT;
                  end
               end
            end
            S_SHIFT: begin
               if (s_amt >= 10'sd64)
                  r_ff <= 64'd0;
               else if (s_amt <= 10'sd0)
                  r_ff <= sum_ff;
               else
                  r_ff <= sum_ff >> s_amt[5:0];
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               dneg_ff  <= r_ff > ONE_Q56;
               state_ff <= S_SCALEW;
            end
            S_SCALEW: begin
               if (mul_done) state_ff <= S_DIVW;
            end
            S_DIVW: begin
               if (div_done) begin
                  rnd_ff   <= div_quo + {72'd0, 1'b1, 55'd0};
                  state_ff <= S_SAT;
               end
            end
            S_SAT: begin
               if (rnd_ff[127:120] != 8'd0 ||
                   rnd_ff[119:56] > {32'd0, (dneg_ff ? LIM_NEG : LIM_POS)}) begin
                  sat_ff   <= 1'b1;
                  speed_ff <= dneg_ff ? LIM_NEG : LIM_POS;
               end else begin
                  speed_ff <= dneg_ff ? 32'd0 - rnd_ff[87:56] : rnd_ff[87:56];
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  out_speed_ff  <= speed_ff;
                  out_status_ff <= status_ff;
                  out_sat_ff    <= sat_ff;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_speed_mm_s = signed'(out_speed_ff);
   assign rsp_status     = out_status_ff;
   assign rsp_saturated  = out_sat_ff;

endmodule

// ----- sv/bvs_mul.sv -----
// Shared 64x64 multiplier built from one 32x32 multiplier over four passes.
// Full 128-bit product; done is registered with the last accumulate, so product is final while done is high.
// Uses bvs_pkg.
module bvs_mul (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   a,
   input  logic [63:0]   b,
   output logic          done,
   output logic [127:0]  product
);
   import bvs_pkg::*;

   logic [63:0]  a_ff, b_ff;
   logic [63:0]  pp_ff;
   logic [1:0]   sh_ff;
   logic [127:0] acc_ff;
   logic [2:0]   cnt_ff;
   logic         busy_ff, done_ff;
   logic [31:0]  pa, pb;
   logic [1:0]   sh_in;
   logic [127:0] pp_shifted;

   assign pa    = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign pb    = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign sh_in = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};

   always_comb begin
      unique case (sh_ff)
         2'd0:    pp_shifted = {64'd0, pp_ff};
         2'd1:    pp_shifted = {32'd0, pp_ff, 32'd0};
         default: pp_shifted = {pp_ff, 64'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            a_ff    <= a;
            b_ff    <= b;
            acc_ff  <= 128'd0;
            cnt_ff  <= 3'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // multiply pass n while pass n-1 is accumulated
            if (cnt_ff != 3'd4) begin
               pp_ff <= pa * pb;
               sh_ff <= sh_in;
            end
            if (cnt_ff != 3'd0)
               acc_ff <= acc_ff + pp_shifted;
            if (cnt_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + 3'd1;
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- sv/bvs_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// 128-bit dividend (64 or 128 bits consumed from the top), 32-bit divisor.
// Uses bvs_pkg.
module bvs_div (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          full,      // 1: 128 quotient bits, 0: 64
   input  logic [127:0]  dividend,
   input  logic [31:0]   divisor,
   output logic          done,
   output logic [127:0]  quotient
);
   import bvs_pkg::*;

   logic [127:0] num_ff, quo_ff;
   logic [31:0]  rem_ff, div_ff;
   logic [6:0]   cnt_ff;
   logic         full_ff, busy_ff, done_ff;
   logic [32:0]  trial, diff;
   logic         qbit;

   assign trial = {rem_ff, num_ff[127]};
   assign diff  = trial - {1'b0, div_ff};
   assign qbit  = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff  <= dividend;
            div_ff  <= divisor;
            full_ff <= full;
            rem_ff  <= 32'd0;
            quo_ff  <= 128'd0;
            cnt_ff  <= 7'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            num_ff <= {num_ff[126:0], 1'b0};
            quo_ff <= {quo_ff[126:0], qbit};
            rem_ff <= qbit ? diff[31:0] : trial[31:0];
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == (full_ff ? 7'd127 : 7'd63)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- bench/bvs_checker.sv -----
// Vertical speed checker: watches request and response transfers, predicts each
// result in fixed point and compares it field by field. Depends on bvs_pkg.
module bvs_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [bvs_pkg::PRESS_W-1:0]         req_pressure,
   input  logic [bvs_pkg::TIME_W-1:0]          req_time_ms,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [bvs_pkg::SPEED_W-1:0]  rsp_speed_mm_s,
   input  logic [bvs_pkg::STAT_W-1:0]          rsp_status,
   input  logic                                rsp_saturated,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  rsp_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import bvs_pkg::*;

   typedef struct packed {
      logic [31:0] speed;
      logic [1:0]  status;
      logic        sat;
   } speed_t;

   speed_t             expected_speeds[$];
   logic [23:0]        held_pressure;
   logic [31:0]        held_time;

   function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = a * b;
      return prod[125:62];
   endfunction

   function automatic logic [63:0] log2_fix(logic [63:0] x);
      int          e;
      logic [63:0] m, res;
      e = 0;
      while (e < 63 && (x >> (e + 1)) != 0) e++;
      m = x << (62 - e);
      res = 64'(e) << 56;
      for (int i = 55; i >= 0; i--) begin
         m = q62_mul(m, m);
         if (m[63]) begin
            m = m >> 1;
            res[i] = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] exp2_fix(logic [63:0] f);
      logic [63:0] x, sum, term;
      x = q62_mul(f << 6, LN2_Q62);
      sum = ONE_Q62;
      term = ONE_Q62;
      for (int k = 1; k <= 40; k++) begin
         term = q62_mul(term, x) / 64'(k);
         if (term == 0) break;
         sum += term;
      end
      return sum;
   endfunction

   function automatic logic [63:0] ratio_pow(logic [63:0] p, logic [63:0] pp);
      logic [63:0] lp, lpp, diff, mag, fr, m;
      longint      n, s;
      logic        neg;
      if (p == 0) return 0;
      lp = log2_fix(p);
      lpp = log2_fix(pp);
      neg = lp < lpp;
      diff = neg ? lpp - lp : lp - lpp;
      mag = q62_mul(diff, EXP_Q62);
      n = longint'(mag >> 56);
      fr = mag & (ONE_Q56 - 1);
      if (neg) begin
         n = -n;
         if (fr != 0) begin
            n -= 1;
            fr = ONE_Q56 - fr;
         end
      end
      m = exp2_fix(fr);
      s = 6 - n;
      if (s >= 64) return 0;
      if (s <= 0) return m;
      return m >> s;
   endfunction

   function automatic speed_t predict_speed(logic [23:0] p, logic [31:0] t);
      speed_t      o;
      logic [31:0] dt;
      logic [63:0] r, d;
      logic [127:0] q;
      logic [71:0] rounded;
      logic [31:0] limit;
      logic        neg;
      o = '0;
      dt = t - held_time;
      if (held_pressure == 0) o.status = STAT_NO_PREV;
      else if (dt == 0) o.status = STAT_ZERO_DT;
      else begin
         o.status = STAT_OK;
         r = ratio_pow(64'(p), 64'(held_pressure));
         neg = r > ONE_Q56;
         d = neg ? r - ONE_Q56 : ONE_Q56 - r;
         q = (128'(d) * 128'(SCALE_MM)) / 128'(dt);
         q = q + (128'd1 << 55);
         rounded = q[127:56];
         limit = neg ? LIM_NEG : LIM_POS;
         if (rounded > 72'(limit)) begin
            rounded = 72'(limit);
            o.sat = 1'b1;
         end
         o.speed = neg ? -rounded[31:0] : rounded[31:0];
      end
      return o;
   endfunction

   assign pending_count = expected_speeds.size();

   always @(posedge clock) begin
      speed_t e;
      if (reset) begin
         held_pressure <= '0;
         held_time <= '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (expected_speeds.size() == 0) begin
               if (fail_count < 10) $display("unexpected response speed=%0d", rsp_speed_mm_s);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_speeds.pop_front();
               if (e.speed !== rsp_speed_mm_s || e.status !== rsp_status ||
                   e.sat !== rsp_saturated) begin
                  if (fail_count < 10)
                     $display("mismatch: exp speed=%0d st=%0d sat=%0d, got %0d %0d %0d",
                              $signed(e.speed), e.status, e.sat,
                              rsp_speed_mm_s, rsp_status, rsp_saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_speeds.push_back(predict_speed(req_pressure, req_time_ms));
            held_pressure <= req_pressure;
            held_time <= req_time_ms;
         end
      end
   end

   initial begin
      fail_count = 0;
      rsp_count = 0;
   end
endmodule

// ----- bench/testbench.sv -----
// Top of the vertical speed bench: clock, reset, sample stimulus, response stalls
// and verdict. Depends on bvs_pkg, barometric_vertical_speed and bvs_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bvs_pkg::*;

   localparam int IDLE_LIMIT = 40000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [23:0] req_pressure = '0;
   logic [31:0] req_time_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic signed [31:0] rsp_speed_mm_s;
   logic [1:0]  rsp_status;
   logic        rsp_saturated;
   int          fail_count, pending_count, rsp_count;
   int          idle_cycles = 0;
   int          hold_off = 0;
   logic [31:0] clock_ms = 32'd1000;

   always #10 clock = ~clock;

   barometric_vertical_speed uut (.*);

   bvs_checker checker_i (.*);

   // watchdog on transfers
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired");
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: own stall pattern, with long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // valid stays high after the transfer; callers drop it before a gap
   task automatic send_sample(input logic [23:0] p, input logic [31:0] t);
      req_valid <= 1'b1;
      req_pressure <= p;
      req_time_ms <= t;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic random_sample();
      logic [23:0] p;
      logic [31:0] t;
      case ($urandom_range(0, 9))
         0: p = 24'($urandom);
         1: p = 24'($urandom_range(0, 3));
         2: p = 24'hFFFFFF - 24'($urandom_range(0, 3));
         default: p = 24'd6_400_000 + 24'($urandom_range(0, 200000)) - 24'd100000;
      endcase
      case ($urandom_range(0, 9))
         0: t = $urandom;
         1: t = clock_ms;
         2: t = clock_ms + $urandom_range(1, 3);
         default: t = clock_ms + $urandom_range(5, 100);
      endcase
      clock_ms = t;
      send_sample(p, t);
   endtask

   initial begin
      int burst;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: no previous, zero dt, zero pressure, extremes, saturation, wrap
      send_sample(24'd6400000, 32'd1000);
      send_sample(24'd6400000, 32'd1000);
      send_sample(24'd6400000, 32'd1020);
      send_sample(24'd6390000, 32'd1040);
      send_sample(24'd6410000, 32'd1060);
      send_sample(24'd0, 32'd1080);
      send_sample(24'd6400000, 32'd1100);
      send_sample(24'd1, 32'd1101);
      send_sample(24'hFFFFFF, 32'd1102);
      send_sample(24'd1, 32'd1103);
      send_sample(24'hFFFFFF, 32'hFFFF_FFFF);
      send_sample(24'd1, 32'd0);
      send_sample(24'hAAAAAA, 32'h5555_5555);
      send_sample(24'h555555, 32'hAAAA_AAAA);
      send_sample(24'h800000, 32'hAAAA_AAAB);
      send_sample(24'h7FFFFF, 32'hAAAA_ABAB);
      send_sample(24'd0, 32'hAAAA_ABAC);
      send_sample(24'd0, 32'hAAAA_ABAD);
      send_sample(24'd6400000, 32'd0);
      clock_ms = 0;
      // long receiver hold-off, longer than two full computations
      hold_off = 9000;
      repeat (5) random_sample();
      // pause until drained
      req_valid <= 1'b0;
      wait (pending_count == 0);
      @(posedge clock);
      for (int n = 0; n < 1500; ) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst; b++) random_sample();
         n += burst;
         if ($urandom_range(0, 2) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (4000) @(posedge clock);
      $display("Covered %0d responses: no-previous, zero-dt, zero pressure, extremes,",
               rsp_count);
      $display("saturation and timestamp wrap, under random source gaps and sink stalls.");
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule

// ----- filelist.f -----
sv/bvs_pkg.sv
sv/bvs_mul.sv
sv/bvs_div.sv
sv/barometric_vertical_speed.sv
bench/bvs_checker.sv
bench/testbench.sv
